// ===== sv/gnsc_pkg.sv =====
// Shared constants, types and the easing table of the gauge needle stepper control.
// Used by the channel interfaces, the controller, the datapath and the top level.
package gnsc_pkg;

  // field widths
  localparam int AngleW    = 12;
  localparam int TempW     = 11;
  localparam int ClampW    = 10;
  localparam int TimeW     = 32;
  localparam int IntervalW = 16;
  localparam int StepW     = 16;
  localparam int DirW      = 2;
  localparam int PointW    = 16;
  localparam int CfgDataW  = 64;
  localparam int CfgIndexW = 3;

  // interpolation table
  localparam int TablePoints = 8;
  localparam int TableW      = 2 * CfgDataW;
  localparam int SegW        = $clog2(TablePoints);
  localparam int TempBase    = 200;
  localparam int TempSpan    = 100;

  // target arithmetic: numerator, its magnitude, reciprocal of 100
  localparam int NumW    = 28;
  localparam int AbsW    = 27;
  localparam int RecipW  = 26;
  localparam int ProdW   = AbsW + RecipW;
  localparam int QuotW   = 21;
  localparam int TgtW    = 22;
  localparam logic [RecipW-1:0] RecipM = RecipW'(42949672);

  // easing
  localparam int EaseWindow = 6;
  localparam int FactorW    = 17;

  // step direction codes
  localparam logic signed [DirW-1:0] DirForward = 2'sb01;
  localparam logic signed [DirW-1:0] DirBack    = 2'sb11;
  localparam logic signed [DirW-1:0] DirStop    = 2'sb00;

  typedef enum logic [CfgIndexW-1:0] {
    REG_HOME_ANGLE    = 3'd0,
    REG_STEP_INTERVAL = 3'd1,
    REG_MIN_TEMP      = 3'd2,
    REG_MAX_TEMP      = 3'd3,
    REG_TABLE_LOW     = 3'd4,
    REG_TABLE_HIGH    = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEGMENT,
    ST_DIVIDE,
    ST_TARGET,
    ST_WAIT,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic capture;
    logic seg_en;
    logic div_en;
    logic tgt_en;
    logic wait_en;
    logic decide_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic homed;
    logic out_busy;
  } dp_status_t;

  // Q1.16 scale 1-(d/6)^0.33 for gaps below the window; gap 0 waits the full interval
  function automatic logic [FactorW-1:0] ease_factor(input logic [2:0] gap);
    logic [FactorW-1:0] f;
    case (gap)
      3'd0:    f = 17'd65536;
      3'd1:    f = 17'd29255;
      3'd2:    f = 17'd19930;
      3'd3:    f = 17'd13400;
      3'd4:    f = 17'd8208;
      3'd5:    f = 17'd3827;
      default: f = 17'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== sv/gnsc_sample_if.sv =====
// Input channel of the gauge needle stepper control: one sensor tick per word.
// Depends on gnsc_pkg for the field widths.
interface gnsc_sample_if;
  logic                        valid;
  logic                        ready;
  logic [gnsc_pkg::AngleW-1:0] measured_angle;
  logic [gnsc_pkg::TempW-1:0]  temperature;
  logic [gnsc_pkg::TimeW-1:0]  time_ms;

  modport source (output valid, measured_angle, temperature, time_ms, input ready);
  modport sink   (input valid, measured_angle, temperature, time_ms, output ready);
endinterface

// ===== sv/gnsc_command_if.sv =====
// Output channel of the gauge needle stepper control: one stepper command per word.
// Depends on gnsc_pkg for the field widths.
interface gnsc_command_if;
  logic                              valid;
  logic                              ready;
  logic signed [gnsc_pkg::DirW-1:0]  step_direction;
  logic                              homed;
  logic signed [gnsc_pkg::StepW-1:0] step_count;

  modport source (output valid, step_direction, homed, step_count, input ready);
  modport sink   (input valid, step_direction, homed, step_count, output ready);
endinterface

// ===== sv/gauge_needle_stepper_control.sv =====
// Top level of the gauge needle stepper control: controller, datapath and channel wiring.
// Depends on gnsc_pkg, gnsc_sample_if, gnsc_command_if, gnsc_ctrl and gnsc_datapath.
//
//   channel   direction  word
//   sample    in         measured_angle, temperature, time_ms
//   command   out        step_direction, homed, step_count
//   cfg       in         cfg_write, cfg_index, cfg_data (no wait, no read-back)
//
// A word taken before homing goes from capture straight to the decide step; a word
// taken after homing passes segment, divide, target and wait stages before the decide
// step loads its command into the output register. The next word is taken once the
// current one has been loaded into the output register. A stalled command holds the
// block in the decide step. Reset clears state.
module gauge_needle_stepper_control (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [gnsc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [gnsc_pkg::CfgDataW-1:0]  cfg_data,
  gnsc_sample_if.sink                    sample,
  gnsc_command_if.source                 command
);

  gnsc_pkg::ctrl_cmd_t  cmd;
  gnsc_pkg::dp_status_t status;

  gnsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gnsc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .measured_angle (sample.measured_angle),
    .temperature    (sample.temperature),
    .time_ms        (sample.time_ms),
    .out_ready      (command.ready),
    .out_valid      (command.valid),
    .step_direction (command.step_direction),
    .homed          (command.homed),
    .step_count     (command.step_count)
  );

  // busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample ready right after an accepted word");

  // once a homed result went out, no later result is unhomed
  a_homed_sticks: assert property (@(posedge clk) disable iff (rst)
    command.valid && command.ready && command.homed |=> !(command.valid && !command.homed))
    else $error("homed dropped after a homed result");

  // no tracking steps are counted before homing
  a_no_steps_unhomed: assert property (@(posedge clk) disable iff (rst)
    command.valid && !command.homed |-> command.step_count == '0)
    else $error("step count moved before homing");

  // direction is always forward, back or stop
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    command.valid |-> command.step_direction != 2'sb10)
    else $error("invalid step direction code");

endmodule

// ===== sv/gnsc_ctrl.sv =====
// Controller of the gauge needle stepper control: sequences one word through the datapath.
// Depends on gnsc_pkg for the state, command and status types.
module gnsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gnsc_pkg::dp_status_t status,
  output gnsc_pkg::ctrl_cmd_t  cmd
);

  gnsc_pkg::state_t state, state_next;

  // hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gnsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // advance: homing words skip the target pipeline
  always_comb begin
    state_next = state;
    case (state)
      gnsc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = status.homed ? gnsc_pkg::ST_SEGMENT : gnsc_pkg::ST_DECIDE;
        end
      end
      gnsc_pkg::ST_SEGMENT: state_next = gnsc_pkg::ST_DIVIDE;
      gnsc_pkg::ST_DIVIDE:  state_next = gnsc_pkg::ST_TARGET;
      gnsc_pkg::ST_TARGET:  state_next = gnsc_pkg::ST_WAIT;
      gnsc_pkg::ST_WAIT:    state_next = gnsc_pkg::ST_DECIDE;
      gnsc_pkg::ST_DECIDE: begin
        if (!status.out_busy) begin
          state_next = gnsc_pkg::ST_IDLE;
        end
      end
      default: state_next = gnsc_pkg::ST_IDLE;
    endcase
  end

  // drive datapath strobes
  always_comb begin
    in_ready      = (state == gnsc_pkg::ST_IDLE);
    cmd.capture   = (state == gnsc_pkg::ST_IDLE) && in_valid;
    cmd.seg_en    = (state == gnsc_pkg::ST_SEGMENT);
    cmd.div_en    = (state == gnsc_pkg::ST_DIVIDE);
    cmd.tgt_en    = (state == gnsc_pkg::ST_TARGET);
    cmd.wait_en   = (state == gnsc_pkg::ST_WAIT);
    cmd.decide_en = (state == gnsc_pkg::ST_DECIDE) && !status.out_busy;
  end

endmodule

// ===== sv/gnsc_datapath.sv =====
// Datapath of the gauge needle stepper control: registers, target interpolation,
// divide by 100, easing wait, step decision and the output register. Depends on gnsc_pkg.
module gnsc_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [gnsc_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [gnsc_pkg::CfgDataW-1:0]        cfg_data,
  input  gnsc_pkg::ctrl_cmd_t                  cmd,
  output gnsc_pkg::dp_status_t                 status,
  input  logic [gnsc_pkg::AngleW-1:0]          measured_angle,
  input  logic [gnsc_pkg::TempW-1:0]           temperature,
  input  logic [gnsc_pkg::TimeW-1:0]           time_ms,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [gnsc_pkg::DirW-1:0]     step_direction,
  output logic                                 homed,
  output logic signed [gnsc_pkg::StepW-1:0]    step_count
);

  // configuration
  logic [gnsc_pkg::AngleW-1:0]    home_angle;
  logic [gnsc_pkg::IntervalW-1:0] step_interval_ms;
  logic [gnsc_pkg::ClampW-1:0]    min_temperature;
  logic [gnsc_pkg::ClampW-1:0]    max_temperature;
  logic [gnsc_pkg::CfgDataW-1:0]  angle_table_low;
  logic [gnsc_pkg::CfgDataW-1:0]  angle_table_high;

  // block state
  logic                          homed_flag;
  logic [gnsc_pkg::TimeW-1:0]    last_step_time;
  logic [gnsc_pkg::ClampW-1:0]   settled_temperature;
  logic                          settled_valid;
  logic [gnsc_pkg::StepW-1:0]    net_steps;

  // captured word and stage registers
  logic [gnsc_pkg::AngleW-1:0]    meas;
  logic [gnsc_pkg::TempW-1:0]     temp;
  logic [gnsc_pkg::TimeW-1:0]     now;
  logic [gnsc_pkg::ClampW-1:0]    temp_clamped;
  logic signed [gnsc_pkg::NumW-1:0] num;
  logic                           num_neg;
  logic [gnsc_pkg::AbsW-1:0]      num_abs;
  logic [gnsc_pkg::ProdW-1:0]     recip_prod;
  logic signed [gnsc_pkg::TgtW-1:0] target;
  logic [gnsc_pkg::TgtW-1:0]      gap;
  logic [gnsc_pkg::IntervalW-1:0] wait_ms;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      home_angle       <= '0;
      step_interval_ms <= gnsc_pkg::IntervalW'(20);
      min_temperature  <= gnsc_pkg::ClampW'(200);
      max_temperature  <= gnsc_pkg::ClampW'(890);
      angle_table_low  <= '0;
      angle_table_high <= '0;
    end else if (cfg_write) begin
      case (gnsc_pkg::cfg_reg_t'(cfg_index))
        gnsc_pkg::REG_HOME_ANGLE:    home_angle       <= cfg_data[gnsc_pkg::AngleW-1:0];
        gnsc_pkg::REG_STEP_INTERVAL: step_interval_ms <= cfg_data[gnsc_pkg::IntervalW-1:0];
        gnsc_pkg::REG_MIN_TEMP:      min_temperature  <= cfg_data[gnsc_pkg::ClampW-1:0];
        gnsc_pkg::REG_MAX_TEMP:      max_temperature  <= cfg_data[gnsc_pkg::ClampW-1:0];
        gnsc_pkg::REG_TABLE_LOW:     angle_table_low  <= cfg_data;
        gnsc_pkg::REG_TABLE_HIGH:    angle_table_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas <= measured_angle;
      temp <= temperature;
      now  <= time_ms;
    end
  end

  // segment stage: clamp, pick segment, form 100*A[i] + delta*(A[i+1]-A[i])
  logic [gnsc_pkg::ClampW-1:0]        t_clamp;
  logic [gnsc_pkg::SegW-1:0]          seg;
  logic [gnsc_pkg::SegW-1:0]          seg_up;
  logic [gnsc_pkg::TempW-1:0]         seg_base;
  logic [gnsc_pkg::TableW-1:0]        points;
  logic [gnsc_pkg::PointW-1:0]        a0, a1;
  logic signed [gnsc_pkg::TempW:0]    delta;
  logic signed [gnsc_pkg::PointW:0]   slope;
  logic signed [gnsc_pkg::TempW+gnsc_pkg::PointW+1:0] ramp;
  logic [gnsc_pkg::PointW+6:0]        a0_scaled;
  logic signed [gnsc_pkg::TempW+gnsc_pkg::PointW+1:0] num_sum;

  always_comb begin
    if (temp < {1'b0, min_temperature}) begin
      t_clamp = min_temperature;
    end else if (temp > {1'b0, max_temperature}) begin
      t_clamp = max_temperature;
    end else begin
      t_clamp = temp[gnsc_pkg::ClampW-1:0];
    end
  end

  // saturate the segment index: the highest point at or below t wins
  always_comb begin
    seg      = '0;
    seg_base = gnsc_pkg::TempW'(gnsc_pkg::TempBase);
    for (int k = 1; k <= gnsc_pkg::TablePoints - 2; k++) begin
      if ({1'b0, t_clamp} >= gnsc_pkg::TempW'(gnsc_pkg::TempBase + gnsc_pkg::TempSpan * k))
      begin
        seg      = gnsc_pkg::SegW'(k);
        seg_base = gnsc_pkg::TempW'(gnsc_pkg::TempBase + gnsc_pkg::TempSpan * k);
      end
    end
  end

  assign points    = {angle_table_high, angle_table_low};
  assign seg_up    = seg + gnsc_pkg::SegW'(1);
  assign a0        = points[{seg, 4'b0000} +: gnsc_pkg::PointW];
  assign a1        = points[{seg_up, 4'b0000} +: gnsc_pkg::PointW];
  assign delta     = $signed({2'b00, t_clamp}) - $signed({1'b0, seg_base});
  assign slope     = $signed({1'b0, a1}) - $signed({1'b0, a0});
  assign ramp      = delta * slope;
  assign a0_scaled = a0 * 7'd100;
  assign num_sum   = ramp + $signed({6'b000000, a0_scaled});

  always_ff @(posedge clk) begin
    if (cmd.seg_en) begin
      temp_clamped <= t_clamp;
      num          <= gnsc_pkg::NumW'(num_sum);
    end
  end

  // divide stage: magnitude times the reciprocal of 100
  logic [gnsc_pkg::AbsW-1:0] abs_c;

  assign abs_c = num[gnsc_pkg::NumW-1] ? gnsc_pkg::AbsW'(-num) : gnsc_pkg::AbsW'(num);

  always_ff @(posedge clk) begin
    if (cmd.div_en) begin
      num_neg    <= num[gnsc_pkg::NumW-1];
      num_abs    <= abs_c;
      recip_prod <= abs_c * gnsc_pkg::RecipM;
    end
  end

  // target stage: correct the quotient by one, restore sign, take the gap
  logic [gnsc_pkg::QuotW-1:0]       quot_est;
  logic [gnsc_pkg::QuotW+6:0]       quot_back;
  logic [gnsc_pkg::AbsW-1:0]        rem;
  logic [gnsc_pkg::QuotW-1:0]       quot;
  logic signed [gnsc_pkg::TgtW-1:0] target_c;
  logic signed [gnsc_pkg::TgtW:0]   gap_s;
  logic [gnsc_pkg::TgtW-1:0]        gap_c;

  assign quot_est  = recip_prod[gnsc_pkg::ProdW-1:32];
  assign quot_back = quot_est * 7'd100;
  assign rem       = num_abs - gnsc_pkg::AbsW'(quot_back);
  assign quot      = (rem >= gnsc_pkg::AbsW'(100)) ? quot_est + gnsc_pkg::QuotW'(1) : quot_est;
  assign target_c  = num_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign gap_s     = target_c - $signed({11'b0, meas});
  assign gap_c     = gap_s[gnsc_pkg::TgtW] ? gnsc_pkg::TgtW'(-gap_s) : gnsc_pkg::TgtW'(gap_s);

  always_ff @(posedge clk) begin
    if (cmd.tgt_en) begin
      target <= target_c;
      gap    <= gap_c;
    end
  end

  // wait stage: scale the interval by the easing factor
  logic [gnsc_pkg::FactorW-1:0]              factor;
  logic [gnsc_pkg::IntervalW+gnsc_pkg::FactorW-1:0] wait_prod;

  assign factor    = (gap < gnsc_pkg::TgtW'(gnsc_pkg::EaseWindow)) ?
                     gnsc_pkg::ease_factor(gap[2:0]) : '0;
  assign wait_prod = step_interval_ms * factor;

  always_ff @(posedge clk) begin
    if (cmd.wait_en) begin
      wait_ms <= wait_prod[31:16];
    end
  end

  // decide: homing, timer, settled check, step toward target
  logic [gnsc_pkg::TimeW-1:0]       elapsed;
  logic signed [gnsc_pkg::TgtW-1:0] meas_s;
  logic                             may_step;
  logic signed [gnsc_pkg::DirW-1:0] dir_next;
  logic                             homed_next;
  logic [gnsc_pkg::StepW-1:0]       steps_next;
  logic                             step_taken;
  logic                             settle_now;

  assign elapsed  = now - last_step_time;
  assign meas_s   = $signed({10'b0, meas});
  assign may_step = (elapsed >= {16'b0, wait_ms}) &&
                    !(settled_valid && (temp_clamped == settled_temperature));

  always_comb begin
    dir_next   = gnsc_pkg::DirStop;
    homed_next = homed_flag;
    steps_next = net_steps;
    step_taken = 1'b0;
    settle_now = 1'b0;
    if (!homed_flag) begin
      if (meas < home_angle) begin
        dir_next = gnsc_pkg::DirForward;
      end else if (meas > home_angle) begin
        dir_next = gnsc_pkg::DirBack;
      end else begin
        homed_next = 1'b1;
      end
    end else if (may_step) begin
      if (meas_s < target) begin
        dir_next   = gnsc_pkg::DirForward;
        steps_next = net_steps + gnsc_pkg::StepW'(1);
        step_taken = 1'b1;
      end else if (meas_s > target) begin
        dir_next   = gnsc_pkg::DirBack;
        steps_next = net_steps - gnsc_pkg::StepW'(1);
        step_taken = 1'b1;
      end else begin
        settle_now = 1'b1;
      end
    end
  end

  // update block state
  always_ff @(posedge clk) begin
    if (rst) begin
      homed_flag          <= 1'b0;
      last_step_time      <= '0;
      settled_temperature <= '0;
      settled_valid       <= 1'b0;
      net_steps           <= '0;
    end else if (cmd.decide_en) begin
      homed_flag <= homed_next;
      net_steps  <= steps_next;
      if (step_taken) begin
        last_step_time <= now;
      end
      if (settle_now) begin
        settled_temperature <= temp_clamped;
        settled_valid       <= 1'b1;
      end
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.decide_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide_en) begin
      step_direction <= dir_next;
      homed          <= homed_next;
      step_count     <= $signed(steps_next);
    end
  end

  assign status.homed    = homed_flag;
  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== tb/gauge_needle_stepper_control_tb.sv =====
// Self-checking testbench for gauge_needle_stepper_control: drives sensor ticks and
// register writes, predicts every stepper command and compares it field by field.
// Depends on gnsc_pkg, gnsc_sample_if, gnsc_command_if and the RTL of the block.
module gauge_needle_stepper_control_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gnsc_pkg::*;

  localparam int AngleMax  = 4095;
  localparam int IdleLimit = 3000;

  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic [TempW-1:0]  temp;
    logic [TimeW-1:0]  stamp;
  } tick_t;

  typedef struct packed {
    logic signed [DirW-1:0]  dir;
    logic                    homed;
    logic signed [StepW-1:0] steps;
  } command_word_t;

  // pseudo-float with a 32-bit mantissa, as used for the easing curve
  typedef struct packed {
    logic [63:0]        man;
    logic signed [31:0] ex;
  } pfloat_t;

  typedef enum int {
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_SCATTER,
    SHAPE_ONES,
    SHAPE_NOISE,
    SHAPE_ZERO
  } table_shape_t;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  cfg_reg_t          cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  gnsc_sample_if  sample_ch ();
  gnsc_command_if command_ch ();

  gauge_needle_stepper_control dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .command   (command_ch)
  );

  // register copies seen by the predictor
  logic [AngleW-1:0]    home_cfg;
  logic [IntervalW-1:0] interval_cfg;
  logic [ClampW-1:0]    tmin_cfg;
  logic [ClampW-1:0]    tmax_cfg;
  logic [TableW-1:0]    table_cfg;

  // predicted needle controller state
  logic              homed_q;
  logic [TimeW-1:0]  last_step_ms;
  logic [TempW-1:0]  settled_temp;
  logic              settled_ok;
  logic [StepW-1:0]  steps_taken;

  tick_t         tick_q[$];
  command_word_t command_due[$];
  int unsigned   items_pushed;
  int unsigned   ticks_taken;
  int unsigned   results_done;
  int unsigned   mismatches;
  logic [TimeW-1:0] now_ms;

  int unsigned src_wait;
  bit          src_calm;
  int unsigned snk_wait;
  int unsigned hold_left;
  bit          snk_calm;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic pfloat_t pf_norm(logic [63:0] m, int e);
    pfloat_t r;
    if (m == 0) begin
      r.man = 0;
      r.ex  = -32'sd1073741824;
      return r;
    end
    while (m >= 64'h1_0000_0000) begin
      m = m >> 1;
      e++;
    end
    while (m < 64'h8000_0000) begin
      m = m << 1;
      e--;
    end
    r.man = m;
    r.ex  = e;
    return r;
  endfunction

  function automatic pfloat_t pf_mul(pfloat_t a, pfloat_t b);
    return pf_norm((a.man * b.man) >> 32, a.ex + b.ex + 32);
  endfunction

  function automatic pfloat_t pf_pow(pfloat_t a, int unsigned n);
    pfloat_t r;
    r = pf_norm(64'd1, 0);
    while (n != 0) begin
      if (n[0]) r = pf_mul(r, a);
      a = pf_mul(a, a);
      n = n >> 1;
    end
    return r;
  endfunction

  function automatic pfloat_t pf_ratio(logic [63:0] num, logic [63:0] den);
    return pf_norm((num << 32) / den, -32);
  endfunction

  function automatic bit pf_le(pfloat_t a, pfloat_t b);
    if (a.ex != b.ex) return a.ex < b.ex;
    return a.man <= b.man;
  endfunction

  // wait before the next step: full interval on target, none outside the window
  function automatic logic [TimeW-1:0] eased_wait(longint gap, logic [IntervalW-1:0] interval);
    pfloat_t     bound;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [63:0] prod;
    if (gap >= EaseWindow) return '0;
    if (gap == 0) return TimeW'(interval);
    bound = pf_pow(pf_ratio(64'(gap), 64'(EaseWindow)), 33);
    lo = 0;
    hi = 65535;
    // largest Q0.16 y with y^100 <= (d/window)^33
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (pf_le(pf_pow(pf_ratio(64'(mid), 64'd65536), 100), bound)) lo = mid;
      else hi = mid - 1;
    end
    prod = 64'(interval) * 64'(65536 - lo);
    return TimeW'(prod >> 16);
  endfunction

  function automatic logic [TempW-1:0] clamp_temp(logic [TempW-1:0] temp);
    if (temp < tmin_cfg) return TempW'(tmin_cfg);
    if (temp > tmax_cfg) return TempW'(tmax_cfg);
    return temp;
  endfunction

  // interpolate the target over the configured points, truncating toward zero
  function automatic longint aim_angle(logic [TempW-1:0] t);
    int unsigned seg;
    longint      a0;
    longint      a1;
    longint      delta;
    seg = t / TempSpan;
    seg = (seg < 2) ? 0 : seg - 2;
    if (seg > TablePoints - 2) seg = TablePoints - 2;
    a0 = table_cfg[seg*PointW +: PointW];
    a1 = table_cfg[(seg+1)*PointW +: PointW];
    delta = longint'(t) - longint'(TempBase + TempSpan * seg);
    return (100 * a0 + delta * (a1 - a0)) / 100;
  endfunction

  task automatic forecast_command(logic [AngleW-1:0] meas, logic [TempW-1:0] temp,
                                  logic [TimeW-1:0] now);
    command_word_t    w;
    logic [TempW-1:0] t;
    longint           aim;
    longint           gap;
    logic [TimeW-1:0] elapsed;
    w.dir = DirStop;
    if (!homed_q) begin
      // homing: head for the home angle, count nothing
      if (meas < home_cfg) w.dir = DirForward;
      else if (meas > home_cfg) w.dir = DirBack;
      else homed_q = 1'b1;
    end else begin
      t   = clamp_temp(temp);
      aim = aim_angle(t);
      gap = aim - longint'(meas);
      if (gap < 0) gap = -gap;
      elapsed = now - last_step_ms;
      if (elapsed >= eased_wait(gap, interval_cfg) && !(settled_ok && t == settled_temp)) begin
        if (longint'(meas) < aim) begin
          w.dir = DirForward;
          steps_taken  = steps_taken + 1'b1;
          last_step_ms = now;
        end else if (longint'(meas) > aim) begin
          w.dir = DirBack;
          steps_taken  = steps_taken - 1'b1;
          last_step_ms = now;
        end else begin
          settled_temp = t;
          settled_ok   = 1'b1;
        end
      end
    end
    w.homed = homed_q;
    w.steps = steps_taken;
    command_due.push_back(w);
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at word %0d: %s got %0d expected %0d", results_done, what, got, want);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_HOME_ANGLE:    home_cfg     = data[AngleW-1:0];
      REG_STEP_INTERVAL: interval_cfg = data[IntervalW-1:0];
      REG_MIN_TEMP:      tmin_cfg     = data[ClampW-1:0];
      REG_MAX_TEMP:      tmax_cfg     = data[ClampW-1:0];
      REG_TABLE_LOW:     table_cfg[CfgDataW-1:0] = data;
      REG_TABLE_HIGH:    table_cfg[TableW-1:CfgDataW] = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // hold the sender until every command is back, then let the pipeline empty
  task automatic wait_idle();
    while (results_done != items_pushed) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_tick(logic [AngleW-1:0] meas, logic [TempW-1:0] temp,
                            logic [TimeW-1:0] stamp);
    tick_t k;
    k.angle = meas;
    k.temp  = temp;
    k.stamp = stamp;
    tick_q.push_back(k);
    items_pushed++;
  endtask

  // place the needle a given offset from the target of this temperature
  task automatic queue_aimed(logic [TempW-1:0] temp, int offset);
    longint pos;
    pos = aim_angle(clamp_temp(temp)) + offset;
    if (pos < 0) pos = 0;
    if (pos > AngleMax) pos = AngleMax;
    queue_tick(AngleW'(pos), temp, now_ms);
  endtask

  function automatic logic [TableW-1:0] make_table(table_shape_t shape);
    logic [TableW-1:0] tbl;
    int unsigned       level;
    tbl   = '0;
    level = $urandom_range(0, 500);
    for (int p = 0; p < TablePoints; p++) begin
      case (shape)
        SHAPE_RISING:  tbl[p*PointW +: PointW] = PointW'(level);
        SHAPE_FALLING: tbl[(TablePoints-1-p)*PointW +: PointW] = PointW'(level);
        SHAPE_SCATTER: tbl[p*PointW +: PointW] = PointW'($urandom_range(0, AngleMax));
        SHAPE_ONES:    tbl[p*PointW +: PointW] = '1;
        SHAPE_NOISE:   tbl[p*PointW +: PointW] = PointW'($urandom);
        default:       tbl[p*PointW +: PointW] = '0;
      endcase
      level = level + $urandom_range(0, 550);
      if (level > AngleMax) level = AngleMax;
    end
    return tbl;
  endfunction

  // runs of a held temperature with the needle near its target, plus some noise
  task automatic queue_tracking(int unsigned n);
    int unsigned      run_left;
    logic [TempW-1:0] held;
    int               offset;
    run_left = 0;
    held     = '0;
    repeat (n) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 12);
        held = ($urandom_range(0, 3) == 0) ? TempW'($urandom_range(0, 2000))
                                           : TempW'($urandom_range(150, 950));
      end
      run_left--;
      if ($urandom_range(0, 19) == 0) now_ms = $urandom;
      else now_ms = now_ms + $urandom_range(0, 40);
      if ($urandom_range(0, 6) == 0) begin
        queue_tick(AngleW'($urandom), TempW'($urandom_range(0, 2000)), now_ms);
      end else begin
        offset = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 12)) - 6;
        queue_aimed(held, offset);
      end
    end
  endtask

  // ---------------------------------------------------------------- sample driver

  always @(posedge clk) begin : drive_ticks
    logic  offer;
    tick_t k;
    if (rst) begin
      sample_ch.valid <= 1'b0;
      src_wait = 0;
    end else begin
      offer = sample_ch.valid;
      // word taken: predict its command and draw the gap before the next one
      if (sample_ch.valid && sample_ch.ready) begin
        forecast_command(sample_ch.measured_angle, sample_ch.temperature, sample_ch.time_ms);
        offer = 1'b0;
        ticks_taken++;
        if (ticks_taken % 40 == 0) src_calm = ($urandom_range(0, 3) == 0);
        src_wait = src_calm ? 0 : $urandom_range(0, 10);
      end
      if (!offer) begin
        if (src_wait != 0) begin
          src_wait--;
        end else if (tick_q.size() != 0) begin
          k = tick_q.pop_front();
          sample_ch.measured_angle <= k.angle;
          sample_ch.temperature    <= k.temp;
          sample_ch.time_ms        <= k.stamp;
          offer = 1'b1;
        end
      end
      sample_ch.valid <= offer;
    end
  end

  // ---------------------------------------------------------------- command monitor

  always @(posedge clk) begin : take_commands
    command_word_t want;
    if (rst) begin
      command_ch.ready <= 1'b0;
      snk_wait  = 0;
      hold_left = 0;
    end else begin
      if (command_ch.valid && command_ch.ready) begin
        results_done++;
        if (command_due.size() == 0) begin
          report_mismatch("unexpected word, step_count", command_ch.step_count, 0);
        end else begin
          want = command_due.pop_front();
          if (command_ch.step_direction !== want.dir)
            report_mismatch("step_direction", command_ch.step_direction, want.dir);
          if (command_ch.homed !== want.homed)
            report_mismatch("homed", command_ch.homed, want.homed);
          if (command_ch.step_count !== want.steps)
            report_mismatch("step_count", command_ch.step_count, want.steps);
        end
        if (results_done % 50 == 0) snk_calm = ($urandom_range(0, 3) == 0);
        snk_wait = snk_calm ? 0 : $urandom_range(0, 10);
        // long stall in mid-phase so the block backs up into its input
        if (results_done == 300 || results_done == 560) hold_left = 150;
      end
      if (hold_left != 0) begin
        hold_left--;
        command_ch.ready <= 1'b0;
      end else if (snk_wait != 0) begin
        snk_wait--;
        command_ch.ready <= 1'b0;
      end else begin
        command_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin : watchdog
    if (rst || (sample_ch.valid && sample_ch.ready) || (command_ch.valid && command_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IdleLimit) begin
        $display("gauge_needle_stepper_control regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin : run_regression
    int unsigned tmin;
    int unsigned tmax;
    logic [TableW-1:0] tbl;
    table_shape_t shape;

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_HOME_ANGLE;
    cfg_data  = '0;
    sample_ch.valid          = 1'b0;
    sample_ch.measured_angle = '0;
    sample_ch.temperature    = '0;
    sample_ch.time_ms        = '0;
    command_ch.ready         = 1'b0;

    home_cfg     = '0;
    interval_cfg = IntervalW'(20);
    tmin_cfg     = ClampW'(200);
    tmax_cfg     = ClampW'(890);
    table_cfg    = '0;
    homed_q      = 1'b0;
    last_step_ms = '0;
    settled_temp = '0;
    settled_ok   = 1'b0;
    steps_taken  = '0;
    items_pushed = 0;
    ticks_taken  = 0;
    results_done = 0;
    mismatches   = 0;
    src_calm     = 1'b0;
    snk_calm     = 1'b0;
    idle_cycles  = 0;
    now_ms       = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // homing toward the top, the bottom and a middle home angle
    write_reg(REG_HOME_ANGLE, CfgDataW'(AngleMax));
    queue_tick('0, TempW'(2000), '1);
    queue_tick(AngleW'(4094), '0, '0);
    wait_idle();
    write_reg(REG_HOME_ANGLE, '0);
    queue_tick(AngleW'(AngleMax), TempW'(1024), 32'h8000_0000);
    queue_tick(AngleW'(1), TempW'(7), 32'd1);
    wait_idle();
    write_reg(REG_HOME_ANGLE, CfgDataW'(1234));
    queue_tick(AngleW'(1233), TempW'(500), 32'd2);
    queue_tick(AngleW'(1235), TempW'(500), 32'd3);
    queue_tick(AngleW'(1234), TempW'(500), 32'd4);
    wait_idle();

    // tracking over a rising table with the default interval and clamps
    write_reg(REG_TABLE_LOW,  {16'd1800, 16'd1200, 16'd700, 16'd300});
    write_reg(REG_TABLE_HIGH, {16'd4000, 16'd3500, 16'd3000, 16'd2400});
    now_ms = 32'd1000;
    now_ms += 100; queue_aimed(TempW'(0), -3);      // below range, clamps to min
    now_ms += 100; queue_aimed(TempW'(2000), 7);    // above range, clamps to max
    now_ms += 100; queue_aimed(TempW'(450), 0);     // on target, latch it
    now_ms += 100; queue_aimed(TempW'(450), 0);     // latched, stay put
    now_ms += 100; queue_aimed(TempW'(450), 3);     // latched even off target
    now_ms += 100; queue_aimed(TempW'(460), -1);    // step
    now_ms += 1;   queue_aimed(TempW'(460), -1);    // too early
    now_ms += 9;   queue_aimed(TempW'(460), -1);    // eased wait elapsed
    now_ms += 5;   queue_aimed(TempW'(300), -2);    // exactly on a table point
    now_ms += 5;   queue_aimed(TempW'(300), 4);
    now_ms += 5;   queue_aimed(TempW'(300), 5);
    now_ms += 5;   queue_aimed(TempW'(300), 6);     // edge of the easing window
    now_ms += 50;  queue_aimed(TempW'(199), 0);
    now_ms += 50;  queue_aimed(TempW'(200), 0);
    now_ms += 50;  queue_aimed(TempW'(900), 1);
    now_ms = 32'hFFFF_FFF0; queue_aimed(TempW'(891), -2);
    now_ms = 32'h0000_0005; queue_aimed(TempW'(891), -2); // timer wraps
    wait_idle();

    // random phases, each with fresh register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1:       begin tmin = 900; tmax = 200; end
        2:       begin tmin = 200; tmax = 900; end
        3:       begin tmin = 550; tmax = 550; end
        default: begin tmin = $urandom_range(200, 900); tmax = $urandom_range(200, 900); end
      endcase
      case (ph)
        0, 5, 7: shape = SHAPE_RISING;
        1:       shape = SHAPE_FALLING;
        2:       shape = SHAPE_SCATTER;
        3:       shape = SHAPE_ONES;
        4:       shape = SHAPE_NOISE;
        default: shape = SHAPE_ZERO;
      endcase
      tbl = make_table(shape);
      write_reg(REG_HOME_ANGLE, CfgDataW'($urandom_range(0, AngleMax)));
      case (ph % 4)
        0:       write_reg(REG_STEP_INTERVAL, '0);
        1:       write_reg(REG_STEP_INTERVAL, CfgDataW'(16'hFFFF));
        2:       write_reg(REG_STEP_INTERVAL, CfgDataW'($urandom_range(1, 100)));
        default: write_reg(REG_STEP_INTERVAL, CfgDataW'($urandom_range(0, 65535)));
      endcase
      write_reg(REG_MIN_TEMP, CfgDataW'(tmin));
      write_reg(REG_MAX_TEMP, CfgDataW'(tmax));
      write_reg(REG_TABLE_LOW,  tbl[CfgDataW-1:0]);
      write_reg(REG_TABLE_HIGH, tbl[TableW-1:CfgDataW]);
      queue_tracking(85);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && command_due.size() == 0) begin
      $display("gauge_needle_stepper_control regression: pass");
    end else begin
      if (command_due.size() != 0)
        report_mismatch("commands never delivered", 0, command_due.size());
      $display("gauge_needle_stepper_control regression: fail");
    end
    $finish;
  end

endmodule
